@@ hw/rtl/rated_table_top_k_select_defines.svh @@
`ifndef RATED_TABLE_TOP_K_SELECT_DEFINES_SVH
`define RATED_TABLE_TOP_K_SELECT_DEFINES_SVH

// Concurrent checks on the block clock, switched off while reset is held.
`define RTKS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`define RTKS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define RTKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/rtks_pkg.sv @@
package rtks_pkg;

  localparam int unsigned KEEP_LIMIT = 16;
  localparam int unsigned KEEP_W     = 5;
  localparam int unsigned QUOT_W     = 16;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned RATING_W   = 8;
  localparam logic [KEEP_W-1:0] SEL_RESET = 5'd2;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_RATE     = 2'd1,
    OP_QUERY    = 2'd2,
    OP_NONE     = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_UNKNOWN   = 2'd2,
    STS_SATURATED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_INSERT,
    CELL_REPLACE,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_UPD_WAIT,
    S_SCAN_RD,
    S_SCAN_LD,
    S_SCAN_MUL,
    S_SCAN_CMP,
    S_OUT_DIV,
    S_OUT_WAIT
  } fsm_e;

  // Status one cell shows its neighbors and the controller.
  typedef struct packed {
    logic valid;
    logic ins;
    logic gt;
  } cell_st_t;

endpackage

@@ hw/rtl/rated_table_top_k_select.sv @@
// Rated table with top-K query. Registering an entry answers on the cycle
// after start. A rating of a known slot takes a table read, an update and a
// 16-step serial division for the reported average; the result word shows
// as busy falls. A query reads, loads, multiplies and compares for each used
// slot (single read port, then one compare in a row of 16 sorting cells) and
// then runs the same serial divider for each entry reported.
// busy is high until the last word of an item has left.
// Each result word is shown for one cycle with result_strobe_o; the receiver
// cannot hold it off. K is read from the configuration register at the start
// of a query and is saturated into 1..16.
`include "rated_table_top_k_select_defines.svh"

module rated_table_top_k_select #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  slot_index_i,
  input  logic [15:0] entry_id_i,
  input  logic [7:0]  rating_value_i,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  output logic        result_strobe_o,
  output logic [1:0]  status_o,
  output logic [3:0]  result_slot_o,
  output logic [15:0] result_id_o,
  output logic [15:0] average_rating_o,
  output logic [15:0] rating_count_o,
  output logic        entry_valid_o,
  output logic        last_item_o
);

  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned SW   = CW + 8;
  localparam int unsigned SLW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned EUW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW = (EUW > 4) ? EUW : 4;
  localparam int unsigned RW   = rtks_pkg::ID_W + SW + CW;
  localparam int unsigned EW   = SLW + RW;
  localparam int unsigned NC   = rtks_pkg::KEEP_LIMIT;
  localparam int unsigned KW   = rtks_pkg::KEEP_W;

  rtks_pkg::fsm_e     state_q, state_d;
  rtks_pkg::opcode_e  opc;
  rtks_pkg::cell_op_e cell_op;

  logic [EUW-1:0] eu_q, scan_q, scan_nx;
  logic [KW-1:0]  n_q, k_q, sel_q, k_clamp;
  logic           accept, eu_full, unknown, scan_last, keep_full;
  logic [CMPW-1:0] slot_ext;

  // Table memory: {id, sum, count} per slot.
  logic           ram_we;
  logic [SLW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0]  ram_wdata, ram_rdata;
  logic [15:0]    rd_id;
  logic [SW-1:0]  rd_sum, new_sum;
  logic [CW-1:0]  rd_cnt, new_cnt;
  logic           rd_sat;

  logic [SLW-1:0]               pend_slot_q;
  logic [15:0]                  pend_id_q;
  logic [CW-1:0]                pend_cnt_q;
  logic [rtks_pkg::RATING_W-1:0] pend_rating_q;
  rtks_pkg::status_e            pend_status_q;

  logic          div_start, div_done;
  logic [SW-1:0] div_sum;
  logic [CW-1:0] div_cnt;
  logic [15:0]   div_quot;

  logic [EW-1:0]      cand_q;
  logic [EW-1:0]      ent [NC];
  rtks_pkg::cell_st_t st [NC];
  logic [SLW-1:0]     h_slot;
  logic [15:0]        h_id;
  logic [SW-1:0]      h_sum;
  logic [CW-1:0]      h_cnt;

  logic        strobe_q;
  logic [1:0]  status_q;
  logic [3:0]  slot_q;
  logic [15:0] id_q, avg_q, cnt_q;
  logic        valid_q, last_q;

  assign opc       = rtks_pkg::opcode_e'(opcode_i);
  assign busy      = (state_q != rtks_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign eu_full   = (eu_q == EUW'(MAX_ENTRIES));
  assign slot_ext  = CMPW'(slot_index_i);
  assign unknown   = (slot_ext >= CMPW'(eu_q));
  assign scan_nx   = scan_q + 1'b1;
  assign scan_last = (scan_nx == eu_q);
  assign keep_full = (n_q == k_q);
  assign k_clamp   = (sel_q == '0) ? KW'(1) :
                     (sel_q > KW'(NC)) ? KW'(NC) : sel_q;

  assign rd_cnt  = ram_rdata[CW-1:0];
  assign rd_sum  = ram_rdata[CW+SW-1:CW];
  assign rd_id   = ram_rdata[RW-1:CW+SW];
  assign rd_sat  = &rd_cnt;
  assign new_sum = rd_sum + SW'(pend_rating_q);
  assign new_cnt = rd_cnt + 1'b1;

  assign h_cnt  = ent[0][CW-1:0];
  assign h_sum  = ent[0][CW+SW-1:CW];
  assign h_id   = ent[0][RW-1:CW+SW];
  assign h_slot = ent[0][EW-1:RW];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtks_pkg::S_IDLE: begin
        if (accept) begin
          unique case (opc)
            rtks_pkg::OP_RATE:  if (!unknown) state_d = rtks_pkg::S_UPD;
            rtks_pkg::OP_QUERY: if (eu_q != '0) state_d = rtks_pkg::S_SCAN_RD;
            rtks_pkg::OP_REGISTER, rtks_pkg::OP_NONE: state_d = rtks_pkg::S_IDLE;
            default: state_d = rtks_pkg::S_IDLE;
          endcase
        end
      end
      rtks_pkg::S_UPD:      state_d = rtks_pkg::S_UPD_WAIT;
      rtks_pkg::S_UPD_WAIT: if (div_done) state_d = rtks_pkg::S_IDLE;
      rtks_pkg::S_SCAN_RD:  state_d = rtks_pkg::S_SCAN_LD;
      rtks_pkg::S_SCAN_LD:  state_d = rtks_pkg::S_SCAN_MUL;
      rtks_pkg::S_SCAN_MUL: state_d = rtks_pkg::S_SCAN_CMP;
      rtks_pkg::S_SCAN_CMP: begin
        state_d = scan_last ? rtks_pkg::S_OUT_DIV : rtks_pkg::S_SCAN_RD;
      end
      rtks_pkg::S_OUT_DIV:  state_d = rtks_pkg::S_OUT_WAIT;
      rtks_pkg::S_OUT_WAIT: begin
        if (div_done) begin
          state_d = (n_q == KW'(1)) ? rtks_pkg::S_IDLE : rtks_pkg::S_OUT_DIV;
        end
      end
      default: state_d = rtks_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_slot_q;
    ram_wdata = {pend_id_q, new_sum, new_cnt};
    ram_raddr = scan_q[SLW-1:0];
    cell_op   = rtks_pkg::CELL_HOLD;
    div_start = 1'b0;
    div_sum   = h_sum;
    div_cnt   = h_cnt;
    unique case (state_q)
      rtks_pkg::S_IDLE: begin
        ram_raddr = slot_ext[SLW-1:0];
        ram_waddr = eu_q[SLW-1:0];
        ram_wdata = {entry_id_i, {SW{1'b0}}, {CW{1'b0}}};
        if (accept && opc == rtks_pkg::OP_REGISTER && !eu_full) begin
          ram_we = 1'b1;
        end
        if (accept && opc == rtks_pkg::OP_QUERY) begin
          cell_op = rtks_pkg::CELL_CLEAR;
        end
      end
      rtks_pkg::S_UPD: begin
        ram_wdata = {rd_id, new_sum, new_cnt};
        ram_we    = !rd_sat;
        div_start = 1'b1;
        div_sum   = rd_sat ? rd_sum : new_sum;
        div_cnt   = rd_sat ? rd_cnt : new_cnt;
      end
      rtks_pkg::S_SCAN_CMP: begin
        if (!keep_full) begin
          cell_op = rtks_pkg::CELL_INSERT;
        end else if (st[0].gt) begin
          cell_op = rtks_pkg::CELL_REPLACE;
        end
      end
      rtks_pkg::S_OUT_DIV: begin
        div_start = 1'b1;
      end
      rtks_pkg::S_OUT_WAIT: begin
        if (div_done) cell_op = rtks_pkg::CELL_SHIFT;
      end
      rtks_pkg::S_UPD_WAIT, rtks_pkg::S_SCAN_RD, rtks_pkg::S_SCAN_LD,
      rtks_pkg::S_SCAN_MUL: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rtks_pkg::S_IDLE;
      eu_q     <= '0;
      scan_q   <= '0;
      n_q      <= '0;
      k_q      <= KW'(1);
      sel_q    <= rtks_pkg::SEL_RESET;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= 1'b0;
      if (cfg_we_i) sel_q <= cfg_wdata_i;
      unique case (state_q)
        rtks_pkg::S_IDLE: begin
          if (accept) begin
            unique case (opc)
              rtks_pkg::OP_REGISTER: begin
                strobe_q <= 1'b1;
                if (!eu_full) eu_q <= eu_q + 1'b1;
              end
              rtks_pkg::OP_RATE: strobe_q <= unknown;
              rtks_pkg::OP_QUERY: begin
                strobe_q <= (eu_q == '0);
                scan_q   <= '0;
                n_q      <= '0;
                k_q      <= k_clamp;
              end
              rtks_pkg::OP_NONE: begin
              end
              default: begin
              end
            endcase
          end
        end
        rtks_pkg::S_SCAN_CMP: begin
          scan_q <= scan_nx;
          if (!keep_full) n_q <= n_q + 1'b1;
        end
        rtks_pkg::S_UPD_WAIT: strobe_q <= div_done;
        rtks_pkg::S_OUT_WAIT: begin
          if (div_done) begin
            strobe_q <= 1'b1;
            n_q      <= n_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result word and operands held across the multi-cycle paths.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rtks_pkg::S_IDLE: begin
        pend_slot_q   <= slot_ext[SLW-1:0];
        pend_rating_q <= rating_value_i;
        status_q <= rtks_pkg::STS_OK;
        slot_q   <= '0;
        id_q     <= '0;
        avg_q    <= '0;
        cnt_q    <= '0;
        valid_q  <= 1'b0;
        last_q   <= 1'b1;
        if (opc == rtks_pkg::OP_REGISTER) begin
          if (eu_full) begin
            status_q <= rtks_pkg::STS_FULL;
          end else begin
            slot_q  <= 4'(eu_q[SLW-1:0]);
            id_q    <= entry_id_i;
            valid_q <= 1'b1;
          end
        end else if (opc == rtks_pkg::OP_RATE) begin
          status_q <= rtks_pkg::STS_UNKNOWN;
        end
      end
      rtks_pkg::S_UPD: begin
        pend_id_q     <= rd_id;
        pend_cnt_q    <= rd_sat ? rd_cnt : new_cnt;
        pend_status_q <= rd_sat ? rtks_pkg::STS_SATURATED : rtks_pkg::STS_OK;
      end
      rtks_pkg::S_UPD_WAIT: begin
        status_q <= pend_status_q;
        slot_q   <= 4'(pend_slot_q);
        id_q     <= pend_id_q;
        avg_q    <= div_quot;
        cnt_q    <= 16'(pend_cnt_q);
        valid_q  <= 1'b1;
        last_q   <= 1'b1;
      end
      rtks_pkg::S_SCAN_LD: begin
        cand_q <= {scan_q[SLW-1:0], ram_rdata};
      end
      rtks_pkg::S_OUT_WAIT: begin
        status_q <= rtks_pkg::STS_OK;
        slot_q   <= 4'(h_slot);
        id_q     <= h_id;
        avg_q    <= div_quot;
        cnt_q    <= 16'(h_cnt);
        valid_q  <= 1'b1;
        last_q   <= (n_q == KW'(1));
      end
      default: begin
      end
    endcase
  end

  rtks_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rtks_div #(
    .CW (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (div_sum),
    .cnt_i   (div_cnt),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Sorted row, lowest ranked entry in cell 0.
  for (genvar i = 0; i < NC; i++) begin : g_cell
    logic [EW-1:0]      prev_ent, next_ent;
    rtks_pkg::cell_st_t prev_st, next_st;
    if (i == 0) begin : g_head
      assign prev_ent = '0;
      assign prev_st  = '{valid: 1'b0, ins: 1'b0, gt: 1'b0};
    end else begin : g_mid
      assign prev_ent = ent[i-1];
      assign prev_st  = st[i-1];
    end
    if (i == NC - 1) begin : g_tail
      assign next_ent = '0;
      assign next_st  = '{valid: 1'b0, ins: 1'b1, gt: 1'b0};
    end else begin : g_body
      assign next_ent = ent[i+1];
      assign next_st  = st[i+1];
    end
    rtks_cell #(
      .SLW      (SLW),
      .CW       (CW),
      .IS_FIRST (i == 0)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (cell_op),
      .cand_i    (cand_q),
      .prev_i    (prev_ent),
      .prev_st_i (prev_st),
      .next_i    (next_ent),
      .next_st_i (next_st),
      .ent_o     (ent[i]),
      .st_o      (st[i])
    );
  end

  assign result_strobe_o  = strobe_q;
  assign status_o         = status_q;
  assign result_slot_o    = slot_q;
  assign result_id_o      = id_q;
  assign average_rating_o = avg_q;
  assign rating_count_o   = cnt_q;
  assign entry_valid_o    = valid_q;
  assign last_item_o      = last_q;

  `RTKS_ASSERT_ALWAYS(a_eu_range, eu_q <= EUW'(MAX_ENTRIES), "entries_used beyond table depth")
  `RTKS_ASSERT_ALWAYS(a_kept_range, n_q <= KW'(NC), "kept set larger than the cell row")
  `RTKS_ASSERT_IMPLY(a_more_words, result_strobe_o && !last_item_o, busy,
    "block idle while a query still owes words")
  `RTKS_ASSERT_NEXT(a_rate_busy, accept && opc == rtks_pkg::OP_RATE && !unknown, busy,
    "rating of a known slot did not start an update")

endmodule

@@ hw/rtl/rtks_ram.sv @@
module rtks_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(DEPTH)-1:0]        waddr_i,
  input  logic [WIDTH-1:0]                wdata_i,
  input  logic [$clog2(DEPTH)-1:0]        raddr_i,
  output logic [WIDTH-1:0]                rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/rtks_div.sv @@
module rtks_div #(
  parameter int unsigned CW = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [CW+7:0]                sum_i,
  input  logic [CW-1:0]                cnt_i,
  output logic                         done_o,
  output logic [rtks_pkg::QUOT_W-1:0]  quot_o
);

  localparam int unsigned QW     = rtks_pkg::QUOT_W;
  localparam int unsigned STEP_W = $clog2(QW);

  logic              run_q, done_q, zero_q;
  logic [STEP_W-1:0] step_q;
  logic [CW-1:0]     rem_q, dvs_q, rem_d;
  logic [QW-1:0]     low_q, q_q;
  logic [CW:0]       trial, diff;
  logic              ge;

  // The average never exceeds 255, so the quotient fits in QW bits and the
  // upper dividend bits start out already below the divisor.
  assign trial = {rem_q, low_q[QW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};
  assign rem_d = ge ? diff[CW-1:0] : trial[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= STEP_W'(QW - 1);
      end else if (run_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= sum_i[CW+7:8];
      low_q  <= {sum_i[7:0], 8'b0};
      dvs_q  <= cnt_i;
      zero_q <= (cnt_i == '0);
      q_q    <= '0;
    end else if (run_q) begin
      rem_q <= rem_d;
      low_q <= {low_q[QW-2:0], 1'b0};
      q_q   <= {q_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = zero_q ? '0 : q_q;

endmodule

@@ hw/rtl/rtks_cell.sv @@
module rtks_cell #(
  parameter int unsigned SLW      = 4,
  parameter int unsigned CW       = 16,
  parameter bit          IS_FIRST = 1'b0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rtks_pkg::cell_op_e         op_i,
  input  logic [SLW+24+2*CW-1:0]     cand_i,
  input  logic [SLW+24+2*CW-1:0]     prev_i,
  input  rtks_pkg::cell_st_t         prev_st_i,
  input  logic [SLW+24+2*CW-1:0]     next_i,
  input  rtks_pkg::cell_st_t         next_st_i,
  output logic [SLW+24+2*CW-1:0]     ent_o,
  output rtks_pkg::cell_st_t         st_o
);

  localparam int unsigned SW = CW + 8;
  localparam int unsigned EW = SLW + 24 + 2 * CW;
  localparam int unsigned PW = SW + CW;

  logic          valid_q, valid_d;
  logic [EW-1:0] ent_q, ent_d;
  logic [PW-1:0] p_ce_q, p_ec_q;
  logic [SW-1:0] c_sum, e_sum;
  logic [CW-1:0] c_cnt, e_cnt;
  logic          c_zero, e_zero, lt, gt, below, ins;

  assign c_cnt  = cand_i[CW-1:0];
  assign c_sum  = cand_i[CW+SW-1:CW];
  assign e_cnt  = ent_q[CW-1:0];
  assign e_sum  = ent_q[CW+SW-1:CW];
  assign c_zero = (c_cnt == '0);
  assign e_zero = (e_cnt == '0);

  // Cross products of candidate and element; both sides hold still for
  // the cycle after these are taken.
  always_ff @(posedge clk_i) begin
    p_ce_q <= c_sum * e_cnt;
    p_ec_q <= e_sum * c_cnt;
  end

  // An entry without ratings has average zero.
  always_comb begin
    if (c_zero) begin
      lt = !e_zero && (e_sum != '0);
      gt = 1'b0;
    end else if (e_zero) begin
      lt = 1'b0;
      gt = (c_sum != '0);
    end else begin
      lt = p_ce_q < p_ec_q;
      gt = p_ce_q > p_ec_q;
    end
  end

  // The candidate is always the latest slot, so a full tie ranks it lower.
  assign below = lt || (!gt && (c_cnt <= e_cnt));
  assign ins   = !valid_q || below;

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    unique case (op_i)
      rtks_pkg::CELL_HOLD: begin
      end
      rtks_pkg::CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      rtks_pkg::CELL_INSERT: begin
        if (prev_st_i.ins) begin
          valid_d = prev_st_i.valid;
          ent_d   = prev_i;
        end else if (ins) begin
          valid_d = 1'b1;
          ent_d   = cand_i;
        end
      end
      rtks_pkg::CELL_REPLACE: begin
        if (next_st_i.valid && !next_st_i.ins) begin
          valid_d = 1'b1;
          ent_d   = next_i;
        end else if (IS_FIRST || !ins) begin
          valid_d = 1'b1;
          ent_d   = cand_i;
        end
      end
      rtks_pkg::CELL_SHIFT: begin
        valid_d = next_st_i.valid;
        ent_d   = next_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o    = ent_q;
  assign st_o.valid = valid_q;
  assign st_o.ins   = ins;
  assign st_o.gt    = gt;

endmodule
